// ===== design/ffha_pkg.sv =====
// shared types and codes for the first-fit heap allocator
// no dependencies; imported by ffha_alu, ffha_engine and the top level
`default_nettype none

package ffha_pkg;

    // command codes carried in the input tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_ALLOC_FAIL   = 2'd1;
    localparam logic [1:0] STAT_FREE_REJECT  = 2'd2;
    localparam logic [1:0] STAT_NULL_FREE    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_BANK0 = 2'd0;
    localparam logic [1:0] REG_BANK1 = 2'd1;
    localparam logic [1:0] REG_BANK2 = 2'd2;

    localparam int CFG_W = 17;

    // operations of the shared add/compare unit
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_DISPATCH,
        ST_A_READ,
        ST_A_CHECK,
        ST_A_UNLINK,
        ST_A_FINAL,
        ST_A_SPLIT,
        ST_A_MIN,
        ST_F_READ,
        ST_F_CHECK,
        ST_I_SCAN,
        ST_I_STEP,
        ST_I_MPREV,
        ST_I_MSUM,
        ST_I_MNEXT,
        ST_I_JOIN,
        ST_I_WRITE,
        ST_I_LINK,
        ST_DONE
    } state_t;

    // one accepted request plus the raw size of its bank
    typedef struct packed {
        logic        cmd;
        logic [1:0]  bank;
        logic [31:0] size;
        logic [15:0] ptr;
        logic        isnull;
        logic [31:0] heap;
    } req_t;

    // one result
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] address;
        logic [16:0] free_bytes;
        logic [16:0] min_free_bytes;
    } res_t;

endpackage

`default_nettype wire

// ===== design/ffha_alu.sv =====
// shared add/subtract unit with borrow and equality flags
// depends on ffha_pkg
`default_nettype none

module ffha_alu
    import ffha_pkg::*;
#(
    parameter int W = 14
)
(
    input  wire alu_op_t        op,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    input  wire logic [W-1:0]   c,
    output logic [W-1:0]        res,
    output logic                borrow,
    output logic                match
);

    logic [W:0] sum;

    // one adder serves both operations
    always_comb
    begin
        case (op)
            ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            default: sum = {1'b0, a} + {1'b0, b};
        endcase
        res    = sum[W-1:0];
        borrow = (op == ALU_SUB) && sum[W];
        match  = (sum == {1'b0, c});
    end

endmodule

`default_nettype wire

// ===== design/ffha_engine.sv =====
// sequencer, header memory and per-bank state of the allocator
// depends on ffha_pkg and ffha_alu
`default_nettype none

module ffha_engine
    import ffha_pkg::*;
#(
    parameter int NUM_BANKS    = 3,
    parameter int HEAP_BYTES   = 65536,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire req_t   req,
    output logic        idle,
    input  wire         slot_free,
    output logic        res_valid,
    output res_t        res
);

    localparam int UNITS  = HEAP_BYTES / ALIGN_BYTES;
    localparam int OW     = $clog2(UNITS);
    localparam int UW     = OW + 1;
    localparam int BW     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int DEPTH  = NUM_BANKS * UNITS;
    localparam int AW     = $clog2(DEPTH);
    localparam int ASH    = $clog2(ALIGN_BYTES);
    localparam int HDR_U  = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int HDR_B  = HDR_U * ALIGN_BYTES;
    localparam int MIN_SPLIT_U = 2 * HDR_U;

    typedef struct packed {
        logic          alloc;
        logic [UW-1:0] size;
        logic [OW-1:0] next;
    } hdr_t;

    function automatic logic [AW-1:0] maddr(input logic [BW-1:0] b, input logic [OW-1:0] o);
        return AW'({b, o});
    endfunction

    // header memory
    hdr_t           mem [DEPTH];
    hdr_t           rdata_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    hdr_t           mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    // control state
    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [NUM_BANKS-1:0] ready_reg, ready_next;
    logic [OW-1:0]  head_reg [NUM_BANKS];
    logic [OW-1:0]  head_next [NUM_BANKS];
    logic [OW-1:0]  end_reg [NUM_BANKS];
    logic [OW-1:0]  end_next [NUM_BANKS];
    logic [UW-1:0]  free_reg [NUM_BANKS];
    logic [UW-1:0]  free_next [NUM_BANKS];
    logic [UW-1:0]  min_reg [NUM_BANKS];
    logic [UW-1:0]  min_next [NUM_BANKS];

    // request and walk payload
    logic           cmd_reg, cmd_next;
    logic [BW-1:0]  bank_reg, bank_next;
    logic           bad_reg, bad_next;
    logic           isnull_reg, isnull_next;
    logic [15:0]    ptr_reg, ptr_next;
    logic [31:0]    heap_reg, heap_next;
    logic [UW-1:0]  want_reg, want_next;
    logic           want_bad_reg, want_bad_next;
    logic [1:0]     status_reg, status_next;
    logic [15:0]    addr_reg, addr_next;
    logic [OW-1:0]  cur_reg, cur_next;
    logic [OW-1:0]  prev_reg, prev_next;
    logic           prev_start_reg, prev_start_next;
    hdr_t           prev_word_reg, prev_word_next;
    logic [UW-1:0]  hsize_reg, hsize_next;
    logic [OW-1:0]  hnext_reg, hnext_next;
    logic [UW-1:0]  rem_reg, rem_next;
    logic           split_reg, split_next;
    logic [OW-1:0]  blk_reg, blk_next;
    logic [UW-1:0]  bsize_reg, bsize_next;
    logic [OW-1:0]  iter_reg, iter_next;
    logic [UW-1:0]  isize_reg, isize_next;
    logic [OW-1:0]  nxt_reg, nxt_next;
    logic           at_start_reg, at_start_next;
    logic [OW-1:0]  icur_reg, icur_next;
    logic [UW-1:0]  csize_reg, csize_next;
    logic [OW-1:0]  cnext_reg, cnext_next;

    // shared unit
    alu_op_t        alu_op;
    logic [UW-1:0]  alu_a, alu_b, alu_c, alu_res;
    logic           alu_borrow, alu_match;

    ffha_alu #(.W(UW)) u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .c      (alu_c),
        .res    (alu_res),
        .borrow (alu_borrow),
        .match  (alu_match)
    );

    // request decode
    logic           in_bank_ok;
    logic           in_ready;
    logic [32:0]    want_wide;
    logic [32:0]    want_units;
    logic [31:0]    clamp_bytes;
    logic [31:0]    init_end;
    logic [31:0]    ptr_blk_b;
    logic           ptr_bad;
    logic           alloc_fail;
    logic           ret_alloc;
    state_t         ret_state;

    always_comb
    begin
        in_bank_ok = (32'(req.bank) < NUM_BANKS);
        in_ready   = in_bank_ok && ready_reg[BW'(req.bank)];
        want_wide  = {1'b0, req.size} + 33'(HDR_B + ALIGN_BYTES - 1);
        want_units = want_wide >> ASH;
    end

    // bank size clamp and end marker for lazy init
    always_comb
    begin
        clamp_bytes = heap_reg;
        if (heap_reg < 32'd16)
            clamp_bytes = 32'd16;
        if (heap_reg > 32'(HEAP_BYTES))
            clamp_bytes = 32'(HEAP_BYTES);
        init_end = (clamp_bytes >= 32'(HDR_B)) ? ((clamp_bytes - 32'(HDR_B)) >> ASH) : 32'd0;
    end

    // pointer checks for a free, allocate failure check and return state
    always_comb
    begin
        ptr_blk_b = 32'(ptr_reg) - 32'(HDR_B);
        ptr_bad   = (32'(ptr_reg) < 32'(HDR_B))
                 || ((ptr_blk_b & 32'(ALIGN_BYTES - 1)) != 32'd0)
                 || ((ptr_blk_b >> ASH) >= 32'(end_reg[bank_reg]));
        alloc_fail = want_bad_reg || (want_reg > free_reg[bank_reg]);
        ret_alloc  = (cmd_reg == CMD_ALLOC);
        ret_state  = ret_alloc ? ST_A_MIN : ST_DONE;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start)
                    state_next = !in_bank_ok ? ST_DONE : (in_ready ? ST_DISPATCH : ST_INIT);
            end
            ST_INIT:     state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                if (cmd_reg == CMD_ALLOC)
                    state_next = alloc_fail ? ST_DONE : ST_A_READ;
                else
                    state_next = (isnull_reg || ptr_bad) ? ST_DONE : ST_F_READ;
            end
            ST_A_READ:   state_next = alu_borrow ? ST_A_CHECK : ST_DONE;
            ST_A_CHECK:  state_next = alu_borrow ? ST_A_READ : ST_A_UNLINK;
            ST_A_UNLINK: state_next = ST_A_FINAL;
            ST_A_FINAL:  state_next = split_reg ? ST_A_SPLIT : ST_A_MIN;
            ST_A_SPLIT:  state_next = ST_I_SCAN;
            ST_A_MIN:    state_next = ST_DONE;
            ST_F_READ:   state_next = ST_F_CHECK;
            ST_F_CHECK:  state_next = rdata_reg.alloc ? ST_I_SCAN : ST_DONE;
            ST_I_SCAN:   state_next = alu_borrow ? ST_I_STEP : ST_I_MPREV;
            ST_I_STEP:   state_next = ST_I_SCAN;
            ST_I_MPREV:  state_next = (!at_start_reg && alu_match) ? ST_I_MSUM : ST_I_MNEXT;
            ST_I_MSUM:   state_next = ST_I_MNEXT;
            ST_I_MNEXT:
            begin
                state_next = (alu_match && (nxt_reg != end_reg[bank_reg])) ? ST_I_JOIN
                                                                           : ST_I_WRITE;
            end
            ST_I_JOIN:   state_next = ST_I_WRITE;
            ST_I_WRITE:
            begin
                state_next = (!at_start_reg && (iter_reg != icur_reg)) ? ST_I_LINK : ret_state;
            end
            ST_I_LINK:   state_next = ret_state;
            ST_DONE:     if (slot_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath, memory control and shared unit operands
    always_comb
    begin
        clr_next        = clr_reg;
        ready_next      = ready_reg;
        head_next       = head_reg;
        end_next        = end_reg;
        free_next       = free_reg;
        min_next        = min_reg;
        cmd_next        = cmd_reg;
        bank_next       = bank_reg;
        bad_next        = bad_reg;
        isnull_next     = isnull_reg;
        ptr_next        = ptr_reg;
        heap_next       = heap_reg;
        want_next       = want_reg;
        want_bad_next   = want_bad_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_start_next = prev_start_reg;
        prev_word_next  = prev_word_reg;
        hsize_next      = hsize_reg;
        hnext_next      = hnext_reg;
        rem_next        = rem_reg;
        split_next      = split_reg;
        blk_next        = blk_reg;
        bsize_next      = bsize_reg;
        iter_next       = iter_reg;
        isize_next      = isize_reg;
        nxt_next        = nxt_reg;
        at_start_next   = at_start_reg;
        icur_next       = icur_reg;
        csize_next      = csize_reg;
        cnext_next      = cnext_reg;
        mem_we          = 1'b0;
        mem_waddr       = maddr(bank_reg, cur_reg);
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = maddr(bank_reg, cur_reg);
        alu_op          = ALU_ADD;
        alu_a           = '0;
        alu_b           = '0;
        alu_c           = '0;

        unique case (state_reg)
            // sweep every header to zero after reset
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            // capture the transaction
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = req.cmd;
                    bank_next     = in_bank_ok ? BW'(req.bank) : '0;
                    bad_next      = !in_bank_ok;
                    isnull_next   = req.isnull;
                    ptr_next      = req.ptr;
                    heap_next     = req.heap;
                    want_next     = want_units[UW-1:0];
                    want_bad_next = (req.size == 32'd0) || req.size[31]
                                 || ((want_units >> UW) != 33'd0);
                    addr_next     = '0;
                    status_next   = STAT_OK;
                    if (!in_bank_ok)
                        status_next = (req.cmd == CMD_FREE) ? STAT_FREE_REJECT : STAT_ALLOC_FAIL;
                end
            end
            // lazy bank setup: one free block from offset zero
            ST_INIT:
            begin
                end_next[bank_reg]  = OW'(init_end);
                head_next[bank_reg] = '0;
                free_next[bank_reg] = UW'(init_end);
                min_next[bank_reg]  = UW'(init_end);
                ready_next[bank_reg] = 1'b1;
                if (init_end != 32'd0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = maddr(bank_reg, '0);
                    mem_wdata = '{alloc: 1'b0, size: UW'(init_end), next: OW'(init_end)};
                end
            end
            ST_DISPATCH:
            begin
                cur_next        = head_reg[bank_reg];
                prev_start_next = 1'b1;
                blk_next        = OW'(ptr_blk_b >> ASH);
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (alloc_fail)
                        status_next = STAT_ALLOC_FAIL;
                end
                else if (isnull_reg)
                    status_next = STAT_NULL_FREE;
                else if (ptr_bad)
                    status_next = STAT_FREE_REJECT;
            end
            // first-fit walk: stop at the end marker
            ST_A_READ:
            begin
                alu_op = ALU_SUB;
                alu_a  = UW'(cur_reg);
                alu_b  = UW'(end_reg[bank_reg]);
                mem_re = alu_borrow;
                if (!alu_borrow)
                    status_next = STAT_ALLOC_FAIL;
            end
            ST_A_CHECK:
            begin
                alu_op = ALU_SUB;
                alu_a  = rdata_reg.size;
                alu_b  = want_reg;
                if (alu_borrow)
                begin
                    prev_next       = cur_reg;
                    prev_word_next  = rdata_reg;
                    prev_start_next = 1'b0;
                    cur_next        = rdata_reg.next;
                end
                else
                begin
                    hsize_next = rdata_reg.size;
                    hnext_next = rdata_reg.next;
                    rem_next   = alu_res;
                end
            end
            // unlink the chosen block and decide on a split
            ST_A_UNLINK:
            begin
                alu_op     = ALU_SUB;
                alu_a      = UW'(MIN_SPLIT_U);
                alu_b      = rem_reg;
                split_next = alu_borrow;
                if (prev_start_reg)
                    head_next[bank_reg] = hnext_reg;
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = maddr(bank_reg, prev_reg);
                    mem_wdata = '{alloc: prev_word_reg.alloc, size: prev_word_reg.size,
                                  next: hnext_reg};
                end
            end
            // mark allocated and take the bytes off the free count
            ST_A_FINAL:
            begin
                alu_op    = ALU_SUB;
                alu_a     = free_reg[bank_reg];
                alu_b     = split_reg ? want_reg : hsize_reg;
                mem_we    = 1'b1;
                mem_waddr = maddr(bank_reg, cur_reg);
                mem_wdata = '{alloc: 1'b1, size: alu_b, next: '0};
                free_next[bank_reg] = alu_borrow ? '0 : alu_res;
                addr_next = 16'((32'(cur_reg) + 32'(HDR_U)) << ASH);
            end
            // write the remainder header and insert it
            ST_A_SPLIT:
            begin
                alu_op        = ALU_ADD;
                alu_a         = UW'(cur_reg);
                alu_b         = want_reg;
                blk_next      = alu_res[OW-1:0];
                bsize_next    = rem_reg;
                nxt_next      = head_reg[bank_reg];
                at_start_next = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = maddr(bank_reg, alu_res[OW-1:0]);
                mem_wdata     = '{alloc: 1'b0, size: rem_reg, next: '0};
            end
            ST_A_MIN:
            begin
                alu_op = ALU_SUB;
                alu_a  = free_reg[bank_reg];
                alu_b  = min_reg[bank_reg];
                if (alu_borrow)
                    min_next[bank_reg] = free_reg[bank_reg];
                status_next = STAT_OK;
            end
            ST_F_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = maddr(bank_reg, blk_reg);
            end
            // header must carry the allocated mark
            ST_F_CHECK:
            begin
                alu_op = ALU_ADD;
                alu_a  = free_reg[bank_reg];
                alu_b  = rdata_reg.size;
                if (rdata_reg.alloc)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = maddr(bank_reg, blk_reg);
                    mem_wdata = '{alloc: 1'b0, size: rdata_reg.size, next: rdata_reg.next};
                    free_next[bank_reg] = alu_res;
                    bsize_next    = rdata_reg.size;
                    nxt_next      = head_reg[bank_reg];
                    at_start_next = 1'b1;
                    status_next   = STAT_OK;
                end
                else
                    status_next = STAT_FREE_REJECT;
            end
            // address-ordered scan for the insert point
            ST_I_SCAN:
            begin
                alu_op    = ALU_SUB;
                alu_a     = UW'(nxt_reg);
                alu_b     = UW'(blk_reg);
                mem_raddr = maddr(bank_reg, nxt_reg);
                if (alu_borrow)
                begin
                    mem_re        = 1'b1;
                    iter_next     = nxt_reg;
                    at_start_next = 1'b0;
                end
            end
            ST_I_STEP:
            begin
                isize_next = rdata_reg.size;
                nxt_next   = rdata_reg.next;
            end
            // merge with the lower neighbor
            ST_I_MPREV:
            begin
                alu_op = ALU_ADD;
                alu_a  = UW'(iter_reg);
                alu_b  = isize_reg;
                alu_c  = UW'(blk_reg);
                if (!at_start_reg && alu_match)
                    icur_next = iter_reg;
                else
                begin
                    icur_next  = blk_reg;
                    csize_next = bsize_reg;
                end
            end
            ST_I_MSUM:
            begin
                alu_op     = ALU_ADD;
                alu_a      = isize_reg;
                alu_b      = bsize_reg;
                csize_next = alu_res;
            end
            // merge with the upper neighbor
            ST_I_MNEXT:
            begin
                alu_op    = ALU_ADD;
                alu_a     = UW'(icur_reg);
                alu_b     = csize_reg;
                alu_c     = UW'(nxt_reg);
                mem_raddr = maddr(bank_reg, nxt_reg);
                if (alu_match && (nxt_reg != end_reg[bank_reg]))
                    mem_re = 1'b1;
                else if (alu_match)
                    cnext_next = end_reg[bank_reg];
                else
                    cnext_next = nxt_reg;
            end
            ST_I_JOIN:
            begin
                alu_op     = ALU_ADD;
                alu_a      = csize_reg;
                alu_b      = rdata_reg.size;
                csize_next = alu_res;
                cnext_next = rdata_reg.next;
            end
            ST_I_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = maddr(bank_reg, icur_reg);
                mem_wdata = '{alloc: 1'b0, size: csize_reg, next: cnext_reg};
                if (at_start_reg)
                    head_next[bank_reg] = icur_reg;
            end
            ST_I_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = maddr(bank_reg, iter_reg);
                mem_wdata = '{alloc: 1'b0, size: isize_reg, next: icur_reg};
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        idle                 = (state_reg == ST_IDLE);
        res_valid            = (state_reg == ST_DONE) && slot_free;
        res.status           = status_reg;
        res.address          = addr_reg;
        res.free_bytes       = bad_reg ? '0 : 17'(32'(free_reg[bank_reg]) << ASH);
        res.min_free_bytes   = bad_reg ? '0 : 17'(32'(min_reg[bank_reg]) << ASH);
    end

    // header memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // control and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ready_reg <= '0;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                head_reg[i] <= '0;
                end_reg[i]  <= '0;
                free_reg[i] <= '0;
                min_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ready_reg <= ready_next;
            head_reg  <= head_next;
            end_reg   <= end_next;
            free_reg  <= free_next;
            min_reg   <= min_next;
        end
    end

    // request and walk payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        bank_reg       <= bank_next;
        bad_reg        <= bad_next;
        isnull_reg     <= isnull_next;
        ptr_reg        <= ptr_next;
        heap_reg       <= heap_next;
        want_reg       <= want_next;
        want_bad_reg   <= want_bad_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_start_reg <= prev_start_next;
        prev_word_reg  <= prev_word_next;
        hsize_reg      <= hsize_next;
        hnext_reg      <= hnext_next;
        rem_reg        <= rem_next;
        split_reg      <= split_next;
        blk_reg        <= blk_next;
        bsize_reg      <= bsize_next;
        iter_reg       <= iter_next;
        isize_reg      <= isize_next;
        nxt_reg        <= nxt_next;
        at_start_reg   <= at_start_next;
        icur_reg       <= icur_next;
        csize_reg      <= csize_next;
        cnext_reg      <= cnext_next;
    end

    // a transaction is only taken by an idle sequencer
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == ST_IDLE))
        else $error("request taken while busy");

    // nothing is taken during the clearing sweep
    a_clear_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !start)
        else $error("request taken during header clear");

    generate
        for (genvar g = 0; g < NUM_BANKS; g++)
        begin : g_bank_chk
            // free count never exceeds the bank's span
            a_free_le_end: assert property (@(posedge clk) disable iff (!rst_n)
                ready_reg[g] |-> (free_reg[g] <= UW'(end_reg[g])))
                else $error("free count beyond bank span");
            // low-water mark never above the free count between requests
            a_min_le_free: assert property (@(posedge clk) disable iff (!rst_n)
                (ready_reg[g] && (state_reg == ST_IDLE)) |-> (min_reg[g] <= free_reg[g]))
                else $error("low-water mark above free count");
        end
    endgenerate

endmodule

`default_nettype wire

// ===== design/first_fit_heap_allocator.sv =====
// top level: configuration registers, stream ports and result register
// depends on ffha_pkg and ffha_engine
//
//  channel   direction  transaction moves
//  s_axis    in         one allocate or free request
//  m_axis    out        one result per request
//  apb       in/out     bank size registers at 0x0, 0x4, 0x8
//
// after reset all NUM_BANKS*HEAP_BYTES/ALIGN_BYTES headers (24576 at defaults)
// are swept to zero before s_axis_tready first rises.
// an allocate walks the bank's free list from its head to the first block that
// fits, plus the insert of a split remainder; a free walks the free blocks below
// it. both walks go through the one header memory port.
// a finished result waits in the output register while the next request runs.
`default_nettype none

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int NUM_BANKS    = 3,
    parameter int HEAP_BYTES   = 65536,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // bank[1:0], request_size[33:2], pointer_offset[49:34], zero fill
    input  wire [55:0]  s_axis_tdata,
    // command[0], pointer_null[1]
    input  wire [1:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // address[15:0], free_bytes[32:16], min_free_bytes[49:33], zero fill
    output logic [55:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CFG_W-1:0] bank0_reg, bank0_next;
    logic [CFG_W-1:0] bank1_reg, bank1_next;
    logic [CFG_W-1:0] bank2_reg, bank2_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;

    logic             cfg_write;
    logic [1:0]       cfg_idx;
    logic             start;
    logic             idle;
    logic             slot_free;
    logic             res_valid;
    req_t             req;
    res_t             res;

    // register file
    always_comb
    begin
        pready     = 1'b1;
        cfg_idx    = paddr[3:2];
        cfg_write  = psel && penable && pwrite;
        bank0_next = bank0_reg;
        bank1_next = bank1_reg;
        bank2_next = bank2_reg;
        prdata     = '0;
        unique case (cfg_idx)
            REG_BANK0: prdata = 32'(bank0_reg);
            REG_BANK1: prdata = 32'(bank1_reg);
            REG_BANK2: prdata = 32'(bank2_reg);
            default:   prdata = '0;
        endcase
        if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_BANK0: bank0_next = pwdata[CFG_W-1:0];
                REG_BANK1: bank1_next = pwdata[CFG_W-1:0];
                REG_BANK2: bank2_next = pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    // request unpack and bank size select
    always_comb
    begin
        s_axis_tready = idle;
        start         = s_axis_tvalid && idle;
        req.cmd       = s_axis_tuser[0];
        req.isnull    = s_axis_tuser[1];
        req.bank      = s_axis_tdata[1:0];
        req.size      = s_axis_tdata[33:2];
        req.ptr       = s_axis_tdata[49:34];
        case (s_axis_tdata[1:0])
            REG_BANK0: req.heap = 32'(bank0_reg);
            REG_BANK1: req.heap = 32'(bank1_reg);
            REG_BANK2: req.heap = 32'(bank2_reg);
            default:   req.heap = 32'(HEAP_BYTES);
        endcase
    end

    ffha_engine #(
        .NUM_BANKS    (NUM_BANKS),
        .HEAP_BYTES   (HEAP_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .idle      (idle),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    always_comb
    begin
        slot_free      = !out_valid_reg || m_axis_tready;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        m_axis_tvalid = out_valid_reg;
        m_axis_tuser  = out_reg.status;
        m_axis_tdata  = {6'd0, out_reg.min_free_bytes, out_reg.free_bytes, out_reg.address};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank0_reg     <= CFG_W'(65536);
            bank1_reg     <= CFG_W'(65536);
            bank2_reg     <= CFG_W'(65536);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bank0_reg     <= bank0_next;
            bank1_reg     <= bank1_next;
            bank2_reg     <= bank2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== verif/tb_first_fit_heap_allocator.sv =====
// self-checking testbench for first_fit_heap_allocator: stream requests in, results checked
// against an in-bench first-fit heap predictor; needs ffha_pkg and the allocator rtl
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int BANKS      = 3;
    localparam int UNIT_COUNT = 8192;
    localparam int HDR        = 8;
    localparam int IDLE_LIMIT = 80000;

    typedef struct {
        logic        cmd;
        logic [1:0]  bank;
        logic [31:0] req_size;
        logic [15:0] ptr;
        logic        is_null;
    } heap_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] address;
        logic [16:0] free_bytes;
        logic [16:0] min_free;
    } heap_res_t;

    typedef struct {
        int unsigned bank;
        int unsigned addr;
    } block_ref_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state of every bank
    int unsigned blk_size [0:BANKS-1][0:UNIT_COUNT-1];
    int unsigned blk_next [0:BANKS-1][0:UNIT_COUNT-1];
    bit          blk_used [0:BANKS-1][0:UNIT_COUNT-1];
    int unsigned head_off [0:BANKS-1];
    int unsigned end_off  [0:BANKS-1];
    int unsigned free_cnt [0:BANKS-1];
    int unsigned low_free [0:BANKS-1];
    bit          bank_up  [0:BANKS-1];
    int unsigned bank_cfg [0:BANKS-1];

    heap_req_t   pending_reqs[$];
    heap_res_t   expected_results[$];
    block_ref_t  live_blocks[$];
    block_ref_t  freed_blocks[$];

    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int          gap_left;
    bit          burst_mode;
    int          stall_left;
    int          results_seen = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int unsigned last_addr;

    first_fit_heap_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned unit_of(int unsigned off);
        return (off / 8) % UNIT_COUNT;
    endfunction

    // lazy bring-up of a bank from its size register
    function automatic void bank_bringup(int b);
        int unsigned sz;
        int unsigned e;
        sz = bank_cfg[b];
        e  = 0;
        if (sz < 16) sz = 16;
        if (sz > 65536) sz = 65536;
        if (sz >= HDR) e = ((sz - HDR) / 8) * 8;
        end_off[b]  = e;
        head_off[b] = e;
        free_cnt[b] = 0;
        if (e > 0)
        begin
            blk_size[b][0] = e;
            blk_next[b][0] = e;
            blk_used[b][0] = 1'b0;
            head_off[b]    = 0;
            free_cnt[b]    = e;
        end
        low_free[b] = free_cnt[b];
        bank_up[b]  = 1'b1;
    endfunction

    // put a block back on the address-ordered free list, merging neighbors
    function automatic void list_insert(int b, int unsigned blk);
        bit          at_head;
        int unsigned prv;
        int unsigned nxt;
        int unsigned cur;
        int          n;
        at_head = 1'b1;
        prv     = 0;
        nxt     = head_off[b];
        cur     = blk;
        n       = 0;
        while (nxt < blk && n <= UNIT_COUNT)
        begin
            prv     = nxt;
            at_head = 1'b0;
            nxt     = blk_next[b][unit_of(prv)];
            n++;
        end
        if (!at_head && prv + blk_size[b][unit_of(prv)] == blk)
        begin
            blk_size[b][unit_of(prv)] += blk_size[b][unit_of(blk)];
            cur = prv;
        end
        if (cur + blk_size[b][unit_of(cur)] == nxt)
        begin
            if (nxt != end_off[b])
            begin
                blk_size[b][unit_of(cur)] += blk_size[b][unit_of(nxt)];
                blk_next[b][unit_of(cur)] = blk_next[b][unit_of(nxt)];
            end
            else
                blk_next[b][unit_of(cur)] = end_off[b];
        end
        else
            blk_next[b][unit_of(cur)] = nxt;
        if (at_head)
            head_off[b] = cur;
        else if (prv != cur)
            blk_next[b][unit_of(prv)] = cur;
    endfunction

    // first-fit allocate; returns payload offset, status through st
    function automatic int unsigned heap_alloc(int b, logic [31:0] req, output logic [1:0] st);
        longint unsigned want;
        int unsigned     prv;
        int unsigned     cur;
        int unsigned     w;
        int unsigned     hu;
        int unsigned     rest;
        int              n;
        bit              prv_head;
        st       = STAT_ALLOC_FAIL;
        prv      = 0;
        n        = 0;
        prv_head = 1'b1;
        if (req == 0 || req[31]) return 0;
        want = longint'(req) + HDR;
        if (want % 8 != 0) want += 8 - (want % 8);
        if (want > free_cnt[b]) return 0;
        w   = int'(want);
        cur = head_off[b];
        while (cur != end_off[b] && blk_size[b][unit_of(cur)] < w && n <= UNIT_COUNT)
        begin
            prv      = cur;
            prv_head = 1'b0;
            cur      = blk_next[b][unit_of(cur)];
            n++;
        end
        if (cur >= end_off[b]) return 0;
        hu = unit_of(cur);
        if (blk_size[b][hu] < w) return 0;
        if (prv_head)
            head_off[b] = blk_next[b][hu];
        else
            blk_next[b][unit_of(prv)] = blk_next[b][hu];
        if (blk_size[b][hu] - w > 2 * HDR)
        begin
            rest = blk_size[b][hu] - w;
            blk_size[b][unit_of(cur + w)] = rest;
            blk_used[b][unit_of(cur + w)] = 1'b0;
            blk_size[b][hu] = w;
            list_insert(b, cur + w);
        end
        free_cnt[b] = (blk_size[b][hu] <= free_cnt[b]) ? free_cnt[b] - blk_size[b][hu] : 0;
        if (free_cnt[b] < low_free[b]) low_free[b] = free_cnt[b];
        blk_used[b][hu] = 1'b1;
        blk_next[b][hu] = 0;
        st = STAT_OK;
        return (cur + HDR) & 16'hFFFF;
    endfunction

    function automatic logic [1:0] heap_release(int b, int unsigned p);
        int unsigned blk;
        if (p < HDR) return STAT_FREE_REJECT;
        blk = p - HDR;
        if (blk % 8 != 0 || blk >= end_off[b]) return STAT_FREE_REJECT;
        if (!blk_used[b][unit_of(blk)]) return STAT_FREE_REJECT;
        blk_used[b][unit_of(blk)] = 1'b0;
        free_cnt[b] += blk_size[b][unit_of(blk)];
        list_insert(b, blk);
        return STAT_OK;
    endfunction

    // predict the result of one request and queue it for the driver
    task automatic issue(logic cmd, int b, logic [31:0] sz, logic [15:0] ptr, logic nul);
        heap_req_t  r;
        heap_res_t  x;
        block_ref_t ref_blk;
        r.cmd = cmd; r.bank = b[1:0]; r.req_size = sz; r.ptr = ptr; r.is_null = nul;
        x.status = STAT_OK; x.address = '0; x.free_bytes = '0; x.min_free = '0;
        last_addr = 0;
        if (b >= BANKS)
            x.status = (cmd == CMD_FREE) ? STAT_FREE_REJECT : STAT_ALLOC_FAIL;
        else
        begin
            if (!bank_up[b]) bank_bringup(b);
            if (cmd == CMD_ALLOC)
            begin
                last_addr = heap_alloc(b, sz, x.status);
                x.address = last_addr[15:0];
                if (x.status == STAT_OK)
                begin
                    ref_blk.bank = b; ref_blk.addr = last_addr;
                    live_blocks.push_back(ref_blk);
                end
            end
            else if (nul)
                x.status = STAT_NULL_FREE;
            else
                x.status = heap_release(b, ptr);
            x.free_bytes = free_cnt[b][16:0];
            x.min_free   = low_free[b][16:0];
        end
        pending_reqs.push_back(r);
        expected_results.push_back(x);
    endtask

    // free a live block by index and remember it for double frees
    task automatic release_live(int idx);
        block_ref_t bref;
        bref = live_blocks[idx];
        live_blocks.delete(idx);
        issue(CMD_FREE, bref.bank, $urandom, bref.addr[15:0], 1'b0);
        freed_blocks.push_back(bref);
        if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        bank_cfg[idx] = val & 32'h1FFFF;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_items(int count);
        int          b;
        int          pick;
        int unsigned sz;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5) b = 3;
            else if (pick < 15) b = 0;
            else b = $urandom_range(1, 2);
            pick = $urandom_range(0, 99);
            if (live_blocks.size() > 0 && (pick < 40 || (live_blocks.size() > 60 && pick < 75)))
                release_live($urandom_range(0, live_blocks.size() - 1));
            else if (pick < 48 && freed_blocks.size() > 0)
                issue(CMD_FREE, freed_blocks[0].bank, 0,
                      freed_blocks[$urandom_range(0, freed_blocks.size() - 1)].addr[15:0], 1'b0);
            else if (pick < 56)
                issue(CMD_FREE, b, $urandom, 16'($urandom), $urandom_range(0, 3) == 0);
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70) sz = $urandom_range(1, 200);
                else if (pick < 90) sz = $urandom_range(200, 3000);
                else if (pick < 95) sz = $urandom_range(3000, 40000);
                else sz = $urandom;
                issue(CMD_ALLOC, b, sz, 16'($urandom), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // stream driver: one request at a time with random gaps
    always @(posedge clk)
    begin
        in_taken  <= s_axis_tvalid && s_axis_tready;
        out_taken <= m_axis_tvalid && m_axis_tready;
    end

    always @(negedge clk or negedge rst_n)
    begin
        heap_req_t r;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            gap_left      <= 0;
            burst_mode    <= 1'b0;
        end
        else if (s_axis_tvalid && !in_taken)
            ;
        else if (gap_left > 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= gap_left - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            r = pending_reqs.pop_front();
            s_axis_tdata  <= {6'b0, r.ptr, r.req_size, r.bank};
            s_axis_tuser  <= {r.is_null, r.cmd};
            s_axis_tvalid <= 1'b1;
            if ($urandom_range(0, 39) == 0) burst_mode <= ~burst_mode;
            gap_left <= burst_mode ? 0 : $urandom_range(0, 13);
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (out_taken)
        begin
            n = burst_mode ? 0 : $urandom_range(0, 13);
            if (results_seen == 300) n = 500;
            stall_left    <= n;
            m_axis_tready <= (n == 0);
        end
        else if (!m_axis_tready)
        begin
            if (stall_left <= 1) m_axis_tready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        heap_res_t x;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result: status %0d addr %0d", m_axis_tuser,
                                 m_axis_tdata[15:0]);
                end
                else
                begin
                    x = expected_results.pop_front();
                    if (m_axis_tuser !== x.status || m_axis_tdata[15:0] !== x.address ||
                        m_axis_tdata[32:16] !== x.free_bytes ||
                        m_axis_tdata[49:33] !== x.min_free)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $write("result %0d: exp st %0d addr %0d free %0d min %0d",
                                   results_seen, x.status, x.address, x.free_bytes,
                                   x.min_free);
                            $display(", got st %0d addr %0d free %0d min %0d",
                                     m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[32:16],
                                     m_axis_tdata[49:33]);
                        end
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("first_fit_heap_allocator regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned a1;
        int unsigned a2;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int b = 0; b < BANKS; b++)
        begin
            bank_up[b] = 1'b0; head_off[b] = 0; end_off[b] = 0;
            free_cnt[b] = 0; low_free[b] = 0; bank_cfg[b] = 65536;
            for (int u = 0; u < UNIT_COUNT; u++)
            begin
                blk_size[b][u] = 0; blk_next[b][u] = 0; blk_used[b][u] = 1'b0;
            end
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // smallest bank, largest bank, oversized value that clamps
        reg_write(REG_BANK0, 16);
        reg_write(REG_BANK1, 65536);
        reg_write(REG_BANK2, 131071);

        // directed: bad requests, bad banks, bad and double frees
        issue(CMD_ALLOC, 1, 0, 16'hFFFF, 1'b1);
        issue(CMD_ALLOC, 1, 32'h8000_0000, 0, 1'b0);
        issue(CMD_ALLOC, 1, 32'hFFFF_FFFF, 0, 1'b0);
        issue(CMD_ALLOC, 1, 1, 0, 1'b0);
        a1 = last_addr;
        issue(CMD_ALLOC, 1, 8, 0, 1'b0);
        issue(CMD_ALLOC, 1, 9, 0, 1'b0);
        a2 = last_addr;
        issue(CMD_ALLOC, 3, 100, 0, 1'b0);
        issue(CMD_FREE, 3, 0, 16'h0010, 1'b0);
        issue(CMD_ALLOC, 0, 1, 0, 1'b0);
        issue(CMD_FREE, 0, 0, 16'h0010, 1'b0);
        issue(CMD_FREE, 0, 0, 16'h1234, 1'b1);
        issue(CMD_FREE, 1, 0, 0, 1'b0);
        issue(CMD_FREE, 1, 0, 13, 1'b0);
        issue(CMD_FREE, 1, 0, 16'hFFFF, 1'b0);
        issue(CMD_FREE, 1, 32'hFFFF_FFFF, a1[15:0], 1'b0);
        issue(CMD_FREE, 1, 0, a1[15:0], 1'b0);
        issue(CMD_FREE, 1, 0, a2[15:0], 1'b0);
        issue(CMD_ALLOC, 1, 65520, 0, 1'b0);
        issue(CMD_ALLOC, 1, 65528, 0, 1'b0);
        issue(CMD_ALLOC, 1, 65536, 0, 1'b0);
        for (int i = 0; i < live_blocks.size(); i++)
            if (live_blocks[i].bank == 1)
                issue(CMD_FREE, 1, 0, live_blocks[i].addr[15:0], 1'b0);
        live_blocks.delete();
        wait_drained();

        // bank 2 untouched so far; late write to bank 0 must be ignored
        reg_write(REG_BANK2, 600);
        reg_write(REG_BANK0, 40000);

        random_items(750);
        // sender pause until everything has come back
        wait_drained();
        random_items(750);
        wait_drained();
        repeat (200) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("first_fit_heap_allocator regression: pass");
        else
            $display("first_fit_heap_allocator regression: fail");
        $finish;
    end

endmodule
